/* hw/rtl/lsc_pkg.sv */
`default_nettype none
package lsc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int CLIP_PASSES = 8;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_BITS    = COORD_BITS / DIV_STAGES;

    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_RIGHT  = 4'b0010;
    localparam logic [3:0] OC_BOTTOM = 4'b0100;
    localparam logic [3:0] OC_TOP    = 4'b1000;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t left;
        coord_t right;
        coord_t bottom;
        coord_t top;
    } win_t;

    typedef struct packed {
        logic   done;
        logic   acc;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } seg_t;

    function automatic logic [3:0] outcode(coord_t x, coord_t y, win_t w);
        logic [3:0] c;
        c = 4'b0000;
        if (x < w.left)   c = c | OC_LEFT;
        if (x > w.right)  c = c | OC_RIGHT;
        if (y < w.bottom) c = c | OC_BOTTOM;
        if (y > w.top)    c = c | OC_TOP;
        return c;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/lsc_pass.sv */
`default_nettype none
module lsc_pass import lsc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire win_t win,
    input  wire logic in_valid,
    input  wire seg_t in_seg,
    output logic      out_valid,
    output seg_t      out_seg
);

    // decide stage
    logic                  d_valid_reg;
    seg_t                  d_seg_reg;
    logic                  d_m_reg, d_horiz_reg, d_neg_reg;
    coord_t                d_edge_reg;
    logic [COORD_BITS-1:0] d_ua_reg, d_ub_reg, d_den_reg;

    // multiply stage
    logic                    p_valid_reg;
    seg_t                    p_seg_reg;
    logic                    p_m_reg, p_horiz_reg, p_neg_reg;
    coord_t                  p_edge_reg;
    logic [COORD_BITS-1:0]   p_den_reg;
    logic [2*COORD_BITS-1:0] p_prod_reg;

    // divide stages
    logic                  v_valid_reg [DIV_STAGES];
    seg_t                  v_seg_reg   [DIV_STAGES];
    logic                  v_m_reg     [DIV_STAGES];
    logic                  v_horiz_reg [DIV_STAGES];
    logic                  v_neg_reg   [DIV_STAGES];
    coord_t                v_edge_reg  [DIV_STAGES];
    logic [COORD_BITS-1:0] v_den_reg   [DIV_STAGES];
    logic [COORD_BITS-1:0] v_rem_reg   [DIV_STAGES];
    logic [COORD_BITS-1:0] v_lo_reg    [DIV_STAGES];
    logic [COORD_BITS-1:0] v_quo_reg   [DIV_STAGES];

    // apply stage
    logic a_valid_reg;
    seg_t a_seg_reg;

    // decide logic
    logic [3:0]          oc0, oc1, c;
    logic                m_next, horiz_next;
    coord_t              edge_next, xm, ym, xo, yo;
    logic signed [COORD_BITS:0] sa, sb, sden;
    seg_t                seg_next;

    function automatic logic [COORD_BITS-1:0] mag(logic signed [COORD_BITS:0] v);
        logic signed [COORD_BITS:0] n;
        n = -v;
        return v[COORD_BITS] ? n[COORD_BITS-1:0] : v[COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        oc0      = outcode(in_seg.x0, in_seg.y0, win);
        oc1      = outcode(in_seg.x1, in_seg.y1, win);
        m_next   = (oc0 == 4'b0000);
        c        = m_next ? oc1 : oc0;
        xm       = m_next ? in_seg.x1 : in_seg.x0;
        ym       = m_next ? in_seg.y1 : in_seg.y0;
        xo       = m_next ? in_seg.x0 : in_seg.x1;
        yo       = m_next ? in_seg.y0 : in_seg.y1;
        seg_next = in_seg;
        if (!in_seg.done)
        begin
            if ((oc0 | oc1) == 4'b0000)
            begin
                seg_next.done = 1'b1;
                seg_next.acc  = 1'b1;
            end
            else if ((oc0 & oc1) != 4'b0000)
            begin
                seg_next.done = 1'b1;
                seg_next.acc  = 1'b0;
            end
        end
        horiz_next = 1'b1;
        priority if ((c & OC_TOP) != 4'b0000)
            edge_next = win.top;
        else if ((c & OC_BOTTOM) != 4'b0000)
            edge_next = win.bottom;
        else if ((c & OC_RIGHT) != 4'b0000)
        begin
            edge_next  = win.right;
            horiz_next = 1'b0;
        end
        else
        begin
            edge_next  = win.left;
            horiz_next = 1'b0;
        end
        if (horiz_next)
        begin
            sa   = {xo[COORD_BITS-1], xo} - {xm[COORD_BITS-1], xm};
            sb   = {edge_next[COORD_BITS-1], edge_next} - {ym[COORD_BITS-1], ym};
            sden = {yo[COORD_BITS-1], yo} - {ym[COORD_BITS-1], ym};
        end
        else
        begin
            sa   = {yo[COORD_BITS-1], yo} - {ym[COORD_BITS-1], ym};
            sb   = {edge_next[COORD_BITS-1], edge_next} - {xm[COORD_BITS-1], xm};
            sden = {xo[COORD_BITS-1], xo} - {xm[COORD_BITS-1], xm};
        end
    end

    // restoring divide, several quotient bits per stage
    typedef struct packed {
        logic [COORD_BITS-1:0] rem;
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] quo;
    } dstep_t;

    function automatic dstep_t div_step(dstep_t s, logic [COORD_BITS-1:0] den);
        dstep_t              r;
        logic [COORD_BITS:0] t;
        r = s;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t = {r.rem, r.lo[COORD_BITS-1]};
            r.lo = {r.lo[COORD_BITS-2:0], 1'b0};
            if (t >= {1'b0, den})
            begin
                t     = t - {1'b0, den};
                r.quo = {r.quo[COORD_BITS-2:0], 1'b1};
            end
            else
                r.quo = {r.quo[COORD_BITS-2:0], 1'b0};
            r.rem = t[COORD_BITS-1:0];
        end
        return r;
    endfunction

    dstep_t ds_in  [DIV_STAGES];
    dstep_t ds_out [DIV_STAGES];

    always_comb
    begin
        ds_in[0] = '{rem: p_prod_reg[2*COORD_BITS-1:COORD_BITS],
                     lo: p_prod_reg[COORD_BITS-1:0], quo: '0};
        ds_out[0] = div_step(ds_in[0], p_den_reg);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            ds_in[k]  = '{rem: v_rem_reg[k-1], lo: v_lo_reg[k-1], quo: v_quo_reg[k-1]};
            ds_out[k] = div_step(ds_in[k], v_den_reg[k-1]);
        end
    end

    // apply logic
    localparam int L = DIV_STAGES - 1;
    logic signed [COORD_BITS:0] q_s, base_s, sum_s;
    seg_t                       a_seg_next;

    always_comb
    begin
        q_s = v_neg_reg[L] ? -$signed({1'b0, v_quo_reg[L]}) : $signed({1'b0, v_quo_reg[L]});
        a_seg_next = v_seg_reg[L];
        if (v_horiz_reg[L])
            base_s = v_m_reg[L] ? {v_seg_reg[L].x1[COORD_BITS-1], v_seg_reg[L].x1}
                                : {v_seg_reg[L].x0[COORD_BITS-1], v_seg_reg[L].x0};
        else
            base_s = v_m_reg[L] ? {v_seg_reg[L].y1[COORD_BITS-1], v_seg_reg[L].y1}
                                : {v_seg_reg[L].y0[COORD_BITS-1], v_seg_reg[L].y0};
        sum_s = base_s + q_s;
        if (!v_seg_reg[L].done)
        begin
            if (v_horiz_reg[L])
            begin
                if (v_m_reg[L])
                begin
                    a_seg_next.x1 = sum_s[COORD_BITS-1:0];
                    a_seg_next.y1 = v_edge_reg[L];
                end
                else
                begin
                    a_seg_next.x0 = sum_s[COORD_BITS-1:0];
                    a_seg_next.y0 = v_edge_reg[L];
                end
            end
            else
            begin
                if (v_m_reg[L])
                begin
                    a_seg_next.y1 = sum_s[COORD_BITS-1:0];
                    a_seg_next.x1 = v_edge_reg[L];
                end
                else
                begin
                    a_seg_next.y0 = sum_s[COORD_BITS-1:0];
                    a_seg_next.x0 = v_edge_reg[L];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
                v_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= in_valid;
            p_valid_reg <= d_valid_reg;
            v_valid_reg[0] <= p_valid_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                v_valid_reg[k] <= v_valid_reg[k-1];
            a_valid_reg <= v_valid_reg[L];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_seg_reg   <= seg_next;
            d_m_reg     <= m_next;
            d_horiz_reg <= horiz_next;
            d_neg_reg   <= sa[COORD_BITS] ^ sb[COORD_BITS] ^ sden[COORD_BITS];
            d_edge_reg  <= edge_next;
            d_ua_reg    <= mag(sa);
            d_ub_reg    <= mag(sb);
            d_den_reg   <= mag(sden);

            p_seg_reg   <= d_seg_reg;
            p_m_reg     <= d_m_reg;
            p_horiz_reg <= d_horiz_reg;
            p_neg_reg   <= d_neg_reg;
            p_edge_reg  <= d_edge_reg;
            p_den_reg   <= d_den_reg;
            p_prod_reg  <= d_ua_reg * d_ub_reg;

            v_seg_reg[0]   <= p_seg_reg;
            v_m_reg[0]     <= p_m_reg;
            v_horiz_reg[0] <= p_horiz_reg;
            v_neg_reg[0]   <= p_neg_reg;
            v_edge_reg[0]  <= p_edge_reg;
            v_den_reg[0]   <= p_den_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                v_seg_reg[k]   <= v_seg_reg[k-1];
                v_m_reg[k]     <= v_m_reg[k-1];
                v_horiz_reg[k] <= v_horiz_reg[k-1];
                v_neg_reg[k]   <= v_neg_reg[k-1];
                v_edge_reg[k]  <= v_edge_reg[k-1];
                v_den_reg[k]   <= v_den_reg[k-1];
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                v_rem_reg[k] <= ds_out[k].rem;
                v_lo_reg[k]  <= ds_out[k].lo;
                v_quo_reg[k] <= ds_out[k].quo;
            end

            a_seg_reg <= a_seg_next;
        end
    end

    assign out_valid = a_valid_reg;
    assign out_seg   = a_seg_reg;

endmodule
`default_nettype wire

/* hw/rtl/lsc_resolve.sv */
`default_nettype none
module lsc_resolve import lsc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire win_t win,
    input  wire logic in_valid,
    input  wire seg_t in_seg,
    output logic      out_valid,
    output logic      out_acc,
    output seg_t      out_seg
);

    logic valid_reg, acc_reg;
    seg_t seg_reg;
    logic acc_next;

    always_comb
    begin
        if (in_seg.done)
            acc_next = in_seg.acc;
        else
            acc_next = ((outcode(in_seg.x0, in_seg.y0, win)
                       | outcode(in_seg.x1, in_seg.y1, win)) == 4'b0000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg <= acc_next;
            seg_reg <= acc_next ? in_seg : '0;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_seg   = seg_reg;

endmodule
`default_nettype wire

/* hw/rtl/line_segment_clipper.sv */
`default_nettype none
// cohen-sutherland line clipper: one segment per transfer on the s_ side, one result per
// transfer on the m_ side, in order; a new segment is taken every cycle unless the m_ side
// stalls, and each segment passes through eight clip passes of seven stages each - decide,
// multiply, four divide stages, apply - then a resolve stage that is the output register;
// a stall on the m_ side freezes the whole pipeline; window registers sit on the apb port
// at 0x0 left, 0x4 right, 0x8 bottom, 0xc top, and must only change while the pipe is empty
module line_segment_clipper import lsc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // segment input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
    // clip result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    output logic             m_tuser    // accepted
);

    win_t win_reg;
    logic adv;

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.left   <= -16'sd6240;
            win_reg.right  <= 16'sd6240;
            win_reg.bottom <= -16'sd6240;
            win_reg.top    <= 16'sd6240;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                REG_LEFT:   win_reg.left   <= pwdata[COORD_BITS-1:0];
                REG_RIGHT:  win_reg.right  <= pwdata[COORD_BITS-1:0];
                REG_BOTTOM: win_reg.bottom <= pwdata[COORD_BITS-1:0];
                REG_TOP:    win_reg.top    <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LEFT:   prdata = {16'd0, win_reg.left};
            REG_RIGHT:  prdata = {16'd0, win_reg.right};
            REG_BOTTOM: prdata = {16'd0, win_reg.bottom};
            REG_TOP:    prdata = {16'd0, win_reg.top};
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // whole pipe moves unless the output register holds an untaken result
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic valid_chain [CLIP_PASSES+1];
    seg_t seg_chain   [CLIP_PASSES+1];

    assign valid_chain[0]   = s_tvalid;
    assign seg_chain[0].done = 1'b0;
    assign seg_chain[0].acc  = 1'b0;
    assign seg_chain[0].x0   = s_tdata[15:0];
    assign seg_chain[0].y0   = s_tdata[31:16];
    assign seg_chain[0].x1   = s_tdata[47:32];
    assign seg_chain[0].y1   = s_tdata[63:48];

    for (genvar g = 0; g < CLIP_PASSES; g++)
    begin : g_pass
        lsc_pass u_pass (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .win       (win_reg),
            .in_valid  (valid_chain[g]),
            .in_seg    (seg_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_seg   (seg_chain[g+1])
        );
    end

    seg_t res_seg;

    lsc_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .win       (win_reg),
        .in_valid  (valid_chain[CLIP_PASSES]),
        .in_seg    (seg_chain[CLIP_PASSES]),
        .out_valid (m_tvalid),
        .out_acc   (m_tuser),
        .out_seg   (res_seg)
    );

    assign m_tdata = {res_seg.y1, res_seg.x1, res_seg.y0, res_seg.x0};

endmodule
`default_nettype wire

/* dv/line_segment_clipper_checker.sv */
`default_nettype none
module line_segment_clipper_checker import lsc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic        m_tuser,
    output int               fail_count,
    output int               pending,
    output int               results_seen,
    output int               accepts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        acc;
        logic [63:0] pts;
    } clip_t;

    clip_t clip_q[$];
    logic signed [15:0] win_l, win_r, win_b, win_t;

    function automatic logic [3:0] region(longint x, longint y);
        logic [3:0] c;
        c = 4'b0000;
        if (x < win_l) c |= OC_LEFT;
        if (x > win_r) c |= OC_RIGHT;
        if (y < win_b) c |= OC_BOTTOM;
        if (y > win_t) c |= OC_TOP;
        return c;
    endfunction

    // a*b/c truncated toward zero, zero divisor gives zero
    function automatic longint scaled(longint a, longint b, longint c);
        if (c == 0) return 0;
        return (a * b) / c;
    endfunction

    function automatic clip_t clip_segment(logic [63:0] d);
        longint x[2], y[2], dx, dy;
        logic [3:0] rc[2];
        logic [3:0] c;
        int m, o;
        clip_t res;
        x[0] = longint'($signed(d[15:0]));
        y[0] = longint'($signed(d[31:16]));
        x[1] = longint'($signed(d[47:32]));
        y[1] = longint'($signed(d[63:48]));
        rc[0] = region(x[0], y[0]);
        rc[1] = region(x[1], y[1]);
        res = '0;
        for (int pass = 0; pass <= CLIP_PASSES; pass++)
        begin
            if ((rc[0] | rc[1]) == 0)
            begin
                res.acc = 1'b1;
                res.pts = {y[1][15:0], x[1][15:0], y[0][15:0], x[0][15:0]};
                break;
            end
            if ((rc[0] & rc[1]) != 0 || pass == CLIP_PASSES) break;
            m = (rc[0] != 0) ? 0 : 1;
            o = 1 - m;
            c = rc[m];
            dx = x[o] - x[m];
            dy = y[o] - y[m];
            if (c & OC_TOP)
            begin
                x[m] += scaled(dx, win_t - y[m], dy);
                y[m] = win_t;
            end
            else if (c & OC_BOTTOM)
            begin
                x[m] += scaled(dx, win_b - y[m], dy);
                y[m] = win_b;
            end
            else if (c & OC_RIGHT)
            begin
                y[m] += scaled(dy, win_r - x[m], dx);
                x[m] = win_r;
            end
            else
            begin
                y[m] += scaled(dy, win_l - x[m], dx);
                x[m] = win_l;
            end
            rc[m] = region(x[m], y[m]);
        end
        return res;
    endfunction

    assign pending = clip_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_l <= -16'sd6240;
            win_r <= 16'sd6240;
            win_b <= -16'sd6240;
            win_t <= 16'sd6240;
            fail_count <= 0;
            results_seen <= 0;
            accepts_seen <= 0;
            clip_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_LEFT:   win_l <= pwdata[15:0];
                    REG_RIGHT:  win_r <= pwdata[15:0];
                    REG_BOTTOM: win_b <= pwdata[15:0];
                    REG_TOP:    win_t <= pwdata[15:0];
                endcase
            end
            if (s_tvalid && s_tready) clip_q.push_back(clip_segment(s_tdata));
            if (m_tvalid && m_tready)
            begin
                clip_t exp_r;
                results_seen <= results_seen + 1;
                if (m_tuser) accepts_seen <= accepts_seen + 1;
                if (clip_q.size() == 0)
                begin
                    if (fail_count < 10) $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = clip_q.pop_front();
                    if (exp_r.acc !== m_tuser || exp_r.pts !== m_tdata)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp acc=%b pts=%h got acc=%b pts=%h",
                                     exp_r.acc, exp_r.pts, m_tuser, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* dv/line_segment_clipper_tb.sv */
`default_nettype none
module line_segment_clipper_tb import lsc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk, rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [63:0] s_tdata;   // start_x, start_y, end_x, end_y
    logic        m_tvalid, m_tready;
    logic [63:0] m_tdata;   // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    logic        m_tuser;   // accepted
    int          fail_count, pending, results_seen, accepts_seen;
    bit          calm;      // no idling on either side while set
    int          segs_sent;

    line_segment_clipper DUT (.*);

    line_segment_clipper_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sink side: random stalls unless calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 15);
    end

    // apb write: setup then access
    task automatic write_window(logic [1:0] idx, logic signed [15:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_window(logic signed [15:0] l, logic signed [15:0] r,
                              logic signed [15:0] b, logic signed [15:0] t);
        write_window(REG_LEFT, l);
        write_window(REG_RIGHT, r);
        write_window(REG_BOTTOM, b);
        write_window(REG_TOP, t);
    endtask

    // one segment transfer, optionally with a random idle gap first
    task automatic send_segment(logic [15:0] x0, logic [15:0] y0,
                                logic [15:0] x1, logic [15:0] y1);
        while (!calm && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y1, x1, y0, x0};
        do @(posedge clk); while (!s_tready);
        segs_sent++;
    endtask

    // coordinate mostly near the window, sometimes anywhere
    function automatic logic [15:0] pick_coord(int span);
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return (r == 1 && $urandom_range(1)) ? 16'h7fff : 16'h8000;
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic random_segments(int n, int span);
        for (int i = 0; i < n; i++)
            send_segment(pick_coord(span), pick_coord(span),
                         pick_coord(span), pick_coord(span));
    endtask

    // drain: stop sending, wait for all results, then let the pipeline empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0;
        calm = 1'b0;
        segs_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed under the reset window
        send_segment(16'd0, 16'd0, 16'd100, 16'd100);            // fully inside
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);    // full diagonal
        send_segment(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);    // vertical, outside
        send_segment(16'd0, 16'h8000, 16'd0, 16'h7fff);          // vertical through
        send_segment(16'h8000, 16'd50, 16'h7fff, 16'd50);        // horizontal through
        send_segment(16'h8000, 16'h8000, 16'h8000, 16'h8000);    // point outside
        send_segment(-16'sd8000, 16'd0, 16'd0, 16'd8000);        // corner miss/hit
        send_segment(16'd7000, 16'd7000, 16'd8000, 16'd100);     // share right
        send_segment(16'd6240, -16'sd6240, -16'sd6240, 16'd6240); // on the edges
        send_segment(-16'sd7000, -16'sd100, 16'd100, 16'd7000);  // two moves
        send_segment(16'hffff, 16'h0001, 16'h5555, 16'haaaa);
        send_segment(16'haaaa, 16'h5555, 16'h0001, 16'hffff);
        // sender holds off until every result is back
        drain();

        // inverted window, then extremes
        set_window(16'sd1000, -16'sd1000, 16'sd1000, -16'sd1000);
        send_segment(16'd0, 16'd0, 16'd10, 16'd10);
        send_segment(-16'sd2000, 16'd0, 16'd2000, 16'd0);
        send_segment(16'd0, -16'sd2000, 16'd0, 16'd2000);
        random_segments(150, 3000);
        drain();
        set_window(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        random_segments(100, 32767);
        drain();
        set_window(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        random_segments(100, 32767);
        drain();
        set_window(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_segment(-16'sd100, -16'sd100, 16'd100, 16'd100);
        random_segments(100, 200);
        drain();
        set_window(-16'sd300, 16'sd500, -16'sd40, 16'sd900);
        random_segments(300, 2000);
        // long stretch with no idling on either side
        calm = 1'b1;
        random_segments(250, 2000);
        calm = 1'b0;
        drain();
        for (int k = 0; k < 4; k++)
        begin
            set_window(16'($signed($urandom_range(8000)) - 6000),
                       16'($signed($urandom_range(8000)) - 2000),
                       16'($signed($urandom_range(8000)) - 6000),
                       16'($signed($urandom_range(8000)) - 2000));
            random_segments(100, 10000);
            drain();
        end

        while (pending != 0) @(posedge clk);
        repeat (70) @(posedge clk);
        $display("sent %0d segments over several windows, normal, inverted and degenerate",
                 segs_sent);
        $display("clipped %0d segments, %0d accepted, %0d rejected",
                 results_seen, accepts_seen, results_seen - accepts_seen);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
